FILE: rtl/positional_list_store_defines.svh
// assertion macros shared by the positional list store rtl
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define PLS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// implication checked on every clock edge outside reset
`define PLS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define PLS_ASSERT(label, prop, msg)
`define PLS_ASSERT_IMPL(label, ante, cons, msg)

`endif

`endif

FILE: rtl/pls_pkg.sv
// types, codes and constants of the positional list store
package pls_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int CMD_W        = 3;
    localparam int POS_W        = 5;
    localparam int WORD_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT      = 3'd0,
        CMD_APPEND      = 3'd1,
        CMD_REMOVE_AT   = 3'd2,
        CMD_REMOVE_LAST = 3'd3,
        CMD_READ        = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // what every cell does this cycle
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_WRITE  = 2'd2,
        OP_REMOVE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [WORD_W-1:0]     word;
    } t_cell_ctl;

endpackage

FILE: rtl/pls_cell.sv
// one storage cell of the list row
module pls_cell #(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  logic                      i_clk,
    input  pls_pkg::t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0]          i_base,
    input  logic [pls_pkg::WORD_W-1:0] i_left,
    input  logic [pls_pkg::WORD_W-1:0] i_right,
    output logic [pls_pkg::WORD_W-1:0] o_word
);
    import pls_pkg::*;

    localparam logic [CNT_W-1:0] IDX_V = CNT_W'(IDX);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    // shift, load or hold depending on where this cell sits against the base index
    always_comb begin
        n_word = r_word;
        unique case (i_ctl.op)
            OP_HOLD: begin
                n_word = r_word;
            end
            OP_INSERT: begin
                if (IDX_V == i_base) begin
                    n_word = i_ctl.word;
                end else if (IDX_V > i_base) begin
                    n_word = i_left;
                end
            end
            OP_WRITE: begin
                if (IDX_V == i_base) begin
                    n_word = i_ctl.word;
                end
            end
            OP_REMOVE: begin
                if (IDX_V >= i_base) begin
                    n_word = i_right;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    // payload storage, no reset
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

FILE: rtl/pls_ctrl.sv
// command decode, status and occupancy counter of the list store
module pls_ctrl #(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  pls_pkg::t_cmd               i_cmd,
    input  logic [pls_pkg::POS_W-1:0]   i_position,
    input  logic [pls_pkg::WORD_W-1:0]  i_word,
    output pls_pkg::t_cell_ctl          o_ctl,
    output logic [CNT_W-1:0]            o_base,
    output pls_pkg::t_status            o_status,
    output logic [CNT_W-1:0]            o_occ,
    output logic [CNT_W-1:0]            o_occ_next
);
    import pls_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_V = CNT_W'(1);

    logic [CNT_W-1:0] r_occ;
    logic [CNT_W-1:0] n_occ;
    logic [CMP_W-1:0] w_occ_x;
    logic [CMP_W-1:0] w_pos_x;
    logic [CNT_W-1:0] w_pos_c;
    logic             w_full;
    logic             w_empty;
    t_cell_op         w_op;

    assign w_occ_x = CMP_W'(r_occ);
    assign w_pos_x = CMP_W'(i_position);
    assign w_pos_c = w_pos_x[CNT_W-1:0];
    assign w_full  = (r_occ == CAP_V);
    assign w_empty = (r_occ == '0);

    // status, cell operation and next count of the command
    always_comb begin
        o_status = ST_OK;
        w_op     = OP_HOLD;
        o_base   = w_pos_c;
        n_occ    = r_occ;
        unique case (i_cmd)
            CMD_INSERT: begin
                if (w_pos_x > w_occ_x) begin
                    o_status = ST_INDEX;
                end else if (w_full) begin
                    o_status = ST_FULL;
                end else begin
                    w_op  = OP_INSERT;
                    n_occ = r_occ + ONE_V;
                end
            end
            CMD_APPEND: begin
                o_base = r_occ;
                if (w_full) begin
                    o_status = ST_FULL;
                end else begin
                    w_op  = OP_WRITE;
                    n_occ = r_occ + ONE_V;
                end
            end
            CMD_REMOVE_AT: begin
                if (w_empty) begin
                    o_status = ST_EMPTY;
                end else if (w_pos_x >= w_occ_x) begin
                    o_status = ST_INDEX;
                end else begin
                    w_op  = OP_REMOVE;
                    n_occ = r_occ - ONE_V;
                end
            end
            CMD_REMOVE_LAST: begin
                if (w_empty) begin
                    o_status = ST_EMPTY;
                end else begin
                    n_occ = r_occ - ONE_V;
                end
            end
            CMD_READ: begin
                if (w_empty) begin
                    o_status = ST_EMPTY;
                end else if (w_pos_x >= w_occ_x) begin
                    o_status = ST_INDEX;
                end
            end
            default: begin
                o_status = ST_OK;
            end
        endcase
    end

    // cells only move on an accepted item
    assign o_ctl.op   = i_accept ? w_op : OP_HOLD;
    assign o_ctl.word = i_word;

    // occupancy counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_accept) begin
            r_occ <= n_occ;
        end
    end

    assign o_occ      = r_occ;
    assign o_occ_next = n_occ;

endmodule

FILE: rtl/positional_list_store.sv
// top level of the positional list store: cell row, decode and result register
//
// Ordered list of up to CAPACITY signed 32-bit words held in a row of cells.
// Commands insert at a position, append, remove at a position, remove the
// last entry or read at a position; each returns one item with a status, the
// word read (zero unless a read succeeds) and the count after the command.
// Every cell shifts, loads or holds in the same cycle, so the block accepts
// one item per clock while the result side takes them; the result item
// appears in the cycle after its command is accepted and is held in an
// output register until taken. Reading the words of entries that were never
// written is not possible, as reads stop at the count.
module positional_list_store #(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [2:0] cmd, [7:3] position, [39:8] word_in
    input  logic [pls_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [1:0] status, [33:2] word_out, [38:34] entry_count, [39] zero
    output logic [pls_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import pls_pkg::*;

    `include "positional_list_store_defines.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int RD_N  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

    logic                w_accept;
    t_cmd                w_cmd;
    logic [POS_W-1:0]    w_pos;
    logic [WORD_W-1:0]   w_word_in;
    t_cell_ctl           w_ctl;
    logic [CNT_W-1:0]    w_base;
    t_status             w_status;
    logic [CNT_W-1:0]    w_occ;
    logic [CNT_W-1:0]    w_occ_next;
    logic [WORD_W-1:0]   w_cells [CAPACITY];
    logic [WORD_W-1:0]   w_rd;
    logic [WORD_W-1:0]   w_word_out;
    logic [CMP_W-1:0]    w_count_x;

    logic                r_m_valid;
    t_status             r_status;
    logic [WORD_W-1:0]   r_word_out;
    logic [COUNT_W-1:0]  r_count;

    // input unpacking and handshake
    assign w_cmd      = t_cmd'(i_s_tdata[CMD_W-1:0]);
    assign w_pos      = i_s_tdata[CMD_W +: POS_W];
    assign w_word_in  = i_s_tdata[CMD_W + POS_W +: WORD_W];
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    pls_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_cmd      (w_cmd),
        .i_position (w_pos),
        .i_word     (w_word_in),
        .o_ctl      (w_ctl),
        .o_base     (w_base),
        .o_status   (w_status),
        .o_occ      (w_occ),
        .o_occ_next (w_occ_next)
    );

    // row of cells, each fed by its neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_W-1:0] w_left;
        logic [WORD_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_word_in;
        end else begin : g_mid_l
            assign w_left = w_cells[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_cells[g];
        end else begin : g_mid_r
            assign w_right = w_cells[g+1];
        end
        pls_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_base  (w_base),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_cells[g])
        );
    end

    // read select over the cells a position can reach
    always_comb begin
        w_rd = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (w_pos == POS_W'(i)) begin
                w_rd = w_cells[i];
            end
        end
    end

    assign w_word_out = ((w_cmd == CMD_READ) && (w_status == ST_OK)) ? w_rd : '0;
    assign w_count_x  = CMP_W'(w_occ_next);

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_accept) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= w_status;
            r_word_out <= w_word_out;
            r_count    <= w_count_x[COUNT_W-1:0];
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_count, r_word_out, r_status};

    // checks on the count and the result contents
    `PLS_ASSERT(a_occ_bound, (w_occ <= CNT_W'(CAPACITY)), "occupancy above capacity")
    `PLS_ASSERT_IMPL(a_fail_no_change, w_accept && (w_status != ST_OK),
        w_occ == $past(w_occ), "failed command changed the count")
    `PLS_ASSERT_IMPL(a_add_inc, w_accept && (w_status == ST_OK) &&
        ((w_cmd == CMD_INSERT) || (w_cmd == CMD_APPEND)),
        w_occ == ($past(w_occ) + CNT_W'(1)), "insert did not raise the count")
    `PLS_ASSERT_IMPL(a_word_zero, w_accept && (w_cmd != CMD_READ),
        r_word_out == '0, "nonzero word on a command other than read")

endmodule
